[sv/spfd_pkg.sv]
// ----------------------------------------------------------------------------
// Single-precision divider package
// Shared widths, status codes and the per-stage record of the divider chain.
// ----------------------------------------------------------------------------
package spfd_pkg;

  localparam int unsigned ExpBias  = 127;
  localparam int unsigned FracBits = 23;
  localparam int unsigned SigBits  = FracBits + 1;
  localparam int unsigned ExpBits  = 8;
  // One quotient bit per cell: 24 bits cover the normalised quotient.
  localparam int unsigned QuoBits  = SigBits;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_SPECIAL   = 2'd3
  } status_t;

  // Record carried from cell to cell.
  typedef struct packed {
    logic                   vld;
    logic                   sign;
    logic                   special;
    logic signed [ExpBits+1:0] expo;
    logic [SigBits:0]       rem;
    logic [SigBits-1:0]     dvs;
    logic [QuoBits-1:0]     quo;
  } stage_t;

endpackage

[sv/spfd_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: compare remainder with divisor, subtract, emit one
// quotient bit and pass the record to the next cell when the chain moves.
// ----------------------------------------------------------------------------
module spfd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  spfd_pkg::stage_t din,
  output spfd_pkg::stage_t dout
);
  import spfd_pkg::*;

  logic [SigBits:0] diff;
  logic             ge;
  stage_t           nxt;

  // Trial subtraction and shift of the partial remainder.
  always_comb begin
    ge   = din.rem >= {1'b0, din.dvs};
    diff = ge ? (din.rem - {1'b0, din.dvs}) : din.rem;
    nxt      = din;
    nxt.rem  = {diff[SigBits-1:0], 1'b0};
    nxt.quo  = {din.quo[QuoBits-2:0], ge};
  end

  // Valid bit is reset; the payload only loads when the chain advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= nxt.vld;
    end
    if (en) begin
      dout.sign    <= nxt.sign;
      dout.special <= nxt.special;
      dout.expo    <= nxt.expo;
      dout.rem     <= nxt.rem;
      dout.dvs     <= nxt.dvs;
      dout.quo     <= nxt.quo;
    end
  end

endmodule

[sv/single_precision_float_divider.sv]
// ----------------------------------------------------------------------------
// Single-precision float divider
// Truncating IEEE-754 single division through a chain of restoring cells.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes one unpack register, 24 divider cells
// and one pack register before it leaves as an output beat.
// Throughput: one beat per cycle; the whole chain advances together, so a
// stall on the output holds every stage.
// Reset: rst clears all valid bits; no data is flushed.
module single_precision_float_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] dividend_bits,
  input  logic [31:0] divisor_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] quotient_bits,
  output logic [1:0]  status
);
  import spfd_pkg::*;

  stage_t chain [0:QuoBits];
  stage_t unpack;
  logic   adv;
  logic [ExpBits-1:0] ea, eb;
  logic [SigBits-1:0] ma, mb;
  logic               lt;
  logic signed [ExpBits+1:0] e_fin;
  logic               norm;

  // The chain moves whenever the output register is free or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Unpack operands and pre-scale the dividend so the quotient is normalised.
  always_comb begin
    ea = dividend_bits[30:23];
    eb = divisor_bits[30:23];
    ma = {1'b1, dividend_bits[22:0]};
    mb = {1'b1, divisor_bits[22:0]};
    lt = ma < mb;
    unpack.vld     = in_valid;
    unpack.sign    = dividend_bits[31] ^ divisor_bits[31];
    unpack.special = (ea == '0) || (ea == '1) || (eb == '0) || (eb == '1);
    unpack.expo    = $signed({2'b00, ea}) - $signed({2'b00, eb})
                     + (ExpBits+2)'(ExpBias) - (lt ? (ExpBits+2)'(1) : '0);
    unpack.rem     = lt ? {ma, 1'b0} : {1'b0, ma};
    unpack.dvs     = mb;
    unpack.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      chain[0].vld <= unpack.vld;
    end
    if (adv) begin
      chain[0].sign    <= unpack.sign;
      chain[0].special <= unpack.special;
      chain[0].expo    <= unpack.expo;
      chain[0].rem     <= unpack.rem;
      chain[0].dvs     <= unpack.dvs;
      chain[0].quo     <= unpack.quo;
    end
  end

  // Row of restoring cells, one quotient bit each.
  for (genvar i = 0; i < QuoBits; i++) begin : g_cell
    spfd_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Range checks and packing into the output register.
  assign e_fin = chain[QuoBits].expo;
  assign norm  = chain[QuoBits].quo[QuoBits-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain[QuoBits].vld;
    end
    if (adv) begin
      if (chain[QuoBits].special) begin
        quotient_bits <= '0;
        status        <= ST_SPECIAL;
      end else if (e_fin >= $signed((ExpBits+2)'(255))) begin
        quotient_bits <= '0;
        status        <= ST_OVERFLOW;
      end else if (e_fin <= $signed((ExpBits+2)'(0))) begin
        quotient_bits <= '0;
        status        <= ST_UNDERFLOW;
      end else begin
        quotient_bits <= {chain[QuoBits].sign, e_fin[ExpBits-1:0],
                          chain[QuoBits].quo[FracBits-1:0]};
        status        <= ST_OK;
      end
    end
  end

  // The leading quotient bit is always set for a normal result.
  a_norm: assert property (@(posedge clk) disable iff (rst)
    chain[QuoBits].vld && !chain[QuoBits].special |-> norm)
    else $error("quotient not normalised");
  // A stalled output holds its beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(quotient_bits))
    else $error("output changed under stall");
  // Nonzero status always carries a zero quotient.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> quotient_bits == '0)
    else $error("flagged result not zero");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Single-precision divider testbench
// Drives directed operand pairs from a table and then random pairs, predicts
// each truncated quotient and status, and checks every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import spfd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] dividend_bits = '0;
  logic [31:0] divisor_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] quotient_bits;
  logic [1:0]  status;

  typedef struct {
    logic [31:0] quo;
    status_t     st;
  } quot_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    logic [31:0] quo;
    status_t     st;
  } vec_t;

  quot_t       pending_quots[$];
  int unsigned errors = 0;
  logic        driving_done = 1'b0;

  single_precision_float_divider DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .dividend_bits(dividend_bits), .divisor_bits(divisor_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .quotient_bits(quotient_bits), .status(status)
  );

  always #5 clk = ~clk;

  // Compute the truncated quotient of two single-precision patterns.
  function automatic quot_t divide_float(logic [31:0] a, logic [31:0] b);
    quot_t       r;
    logic [7:0]  ea, eb;
    logic [47:0] ma, mb, q;
    int          e;
    ea = a[30:23];
    eb = b[30:23];
    ma = {24'd0, 1'b1, a[22:0]};
    mb = {24'd0, 1'b1, b[22:0]};
    r.quo = '0;
    if (ea == 8'd0 || ea == 8'hFF || eb == 8'd0 || eb == 8'hFF) begin
      r.st = ST_SPECIAL;
      return r;
    end
    e = int'(ea) - int'(eb) + int'(ExpBias);
    if (ma >= mb) begin
      q = (ma << FracBits) / mb;
    end else begin
      q = (ma << (FracBits + 1)) / mb;
      e = e - 1;
    end
    if (e >= 255) begin
      r.st = ST_OVERFLOW;
    end else if (e <= 0) begin
      r.st = ST_UNDERFLOW;
    end else begin
      r.st = ST_OK;
      r.quo = {a[31] ^ b[31], e[7:0], q[22:0]};
    end
    return r;
  endfunction

  // Random operand: mostly ordinary exponents, sometimes any pattern.
  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      v[30:23] = 8'($urandom_range(1, 254));
    end
    return v;
  endfunction

  // Hand one operand pair to the divider and wait for its acceptance.
  // Valid stays high after acceptance so that pairs can follow back to back.
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    dividend_bits <= a;
    divisor_bits  <= b;
    pending_quots = {pending_quots, divide_float(a, b)};
    do @(posedge clk); while (in_stall);
  endtask

  // Stimulus: directed table, then random pairs.
  initial begin
    vec_t vecs[$];
    vec_t v;
    quot_t p;
    vecs = '{
      '{32'h3F800000, 32'h3F800000, 1'b1, 32'h3F800000, ST_OK},
      '{32'hBF800000, 32'h3F800000, 1'b1, 32'hBF800000, ST_OK},
      '{32'h40000000, 32'hC0000000, 1'b1, 32'hBF800000, ST_OK},
      '{32'h00000000, 32'h3F800000, 1'b1, 32'h0, ST_SPECIAL},
      '{32'h3F800000, 32'h80000000, 1'b1, 32'h0, ST_SPECIAL},
      '{32'h007FFFFF, 32'h3F800000, 1'b1, 32'h0, ST_SPECIAL},
      '{32'h7F800000, 32'h3F800000, 1'b1, 32'h0, ST_SPECIAL},
      '{32'h3F800000, 32'hFFFFFFFF, 1'b1, 32'h0, ST_SPECIAL},
      '{32'h7F7FFFFF, 32'h00800000, 1'b1, 32'h0, ST_OVERFLOW},
      '{32'h7F7FFFFF, 32'h00800001, 1'b1, 32'h0, ST_OVERFLOW},
      '{32'h7F000000, 32'h3E800000, 1'b1, 32'h0, ST_OVERFLOW},
      '{32'h00800000, 32'h7F000000, 1'b1, 32'h0, ST_UNDERFLOW},
      '{32'h00800000, 32'h3FFFFFFF, 1'b1, 32'h0, ST_UNDERFLOW},
      '{32'h3F800000, 32'h3FFFFFFF, 1'b0, 32'h0, ST_OK},
      '{32'h3FFFFFFF, 32'h3F800000, 1'b0, 32'h0, ST_OK},
      '{32'h7F7FFFFF, 32'h3F800000, 1'b0, 32'h0, ST_OK},
      '{32'h7F7FFFFF, 32'h3F7FFFFF, 1'b0, 32'h0, ST_OK},
      '{32'h00800000, 32'h3F800000, 1'b0, 32'h0, ST_OK},
      '{32'h00FFFFFF, 32'h3FFFFFFF, 1'b0, 32'h0, ST_OK},
      '{32'h40400000, 32'h40400000, 1'b0, 32'h0, ST_OK},
      '{32'hC0A00000, 32'h40400000, 1'b0, 32'h0, ST_OK},
      '{32'h3FAAAAAB, 32'hBF555555, 1'b0, 32'h0, ST_OK}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (vecs[i]) begin
      v = vecs[i];
      // Typed rows are checked against the predictor before the row is driven.
      if (v.typed) begin
        p = divide_float(v.a, v.b);
        if (p.quo !== v.quo || p.st !== v.st) begin
          $error("table row %0d: quotient_bits expected %h got %h, status expected %0d got %0d",
                 i, v.quo, p.quo, v.st, p.st);
          errors++;
        end
      end
      send_pair(v.a, v.b);
    end
    for (int n = 0; n < 750; n++) begin
      // Once in the middle, let the pipeline drain completely.
      if (n == 375) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_quots.size() != 0) @(posedge clk);
      end
      send_pair(rand_float(), rand_float());
    end
    in_valid     <= 1'b0;
    driving_done <= 1'b1;
  end

  // Receiver: random stalls, with runs of none.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 7) == 0) hold = $urandom_range(0, 18);
      end
    end
  end

  // Check each output beat against the oldest prediction.
  always @(posedge clk) begin
    quot_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_quots.size() == 0) begin
        $error("unexpected output beat: quotient_bits %h status %0d", quotient_bits, status);
        errors++;
      end else begin
        x = pending_quots.pop_front();
        if (quotient_bits !== x.quo) begin
          $error("quotient_bits expected %h actual %h", x.quo, quotient_bits);
          errors++;
        end
        if (status !== x.st) begin
          $error("status expected %0d actual %0d", x.st, status);
          errors++;
        end
      end
    end
  end

  // End of run once everything is drained.
  initial begin
    wait (driving_done);
    while (pending_quots.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_quots.size() == 0) begin
      $display("single_precision_float_divider: match");
    end else begin
      $display("single_precision_float_divider: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("single_precision_float_divider: mismatch");
    $finish;
  end

endmodule

[filelist.f]
sv/spfd_pkg.sv
sv/spfd_cell.sv
sv/single_precision_float_divider.sv
verif/tb_top.sv
